// ----- hw/rtl/kmt_pkg.sv -----
// ----------------------------------------------------------------------------
// kmt_pkg - shared types and codes of the keyed max table
// Command codes, request/response payloads and the record that travels
// from cell to cell along the table.
// ----------------------------------------------------------------------------
`default_nettype none

package kmt_pkg;

	localparam int DATA_W          = 32;
	localparam int COUNT_W         = 5;
	localparam int ENTRIES_DEFAULT = 16;

	localparam logic OP_SET    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] max_value;
		logic [COUNT_W-1:0]       entry_count;
		logic                     dropped;
	} rsp_t;

	// command as broadcast to every cell; hit = key is held somewhere
	typedef struct packed {
		logic                     cmd;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] amount;
		logic                     hit;
	} cmd_t;

	// running record handed from one cell to the next
	typedef struct packed {
		logic                     strobe;
		logic                     any;
		logic signed [DATA_W-1:0] best;
		logic                     claimed;
	} carry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/kmt_chan_if.sv -----
// ----------------------------------------------------------------------------
// kmt_chan_if - valid/ready channel
// One request moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface kmt_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/keyed_max_table.sv -----
// ----------------------------------------------------------------------------
// keyed_max_table - keyed table of signed amounts reporting the maximum
// Set/remove commands on up to ENTRIES keys; one response per command.
// ----------------------------------------------------------------------------
// Usage:
//   req carries {cmd, key, amount}; cmd 0 sets the amount for key (update in
//   place or take the lowest free slot), cmd 1 removes key if present.
//   rsp carries {max_value, entry_count, dropped} after the command;
//   max_value is 0 on an empty table, entry_count is the low 5 bits of the
//   number of held keys, dropped flags a new key refused by a full table.
// Timing:
//   One request at a time. After acceptance the match state compares the key
//   in all cells in parallel, then a wave walks the cell chain one cell per
//   cycle, updating the slot and folding max and count. The response is
//   registered once the wave has left the chain tail and the output register
//   is free. req.ready rises at the same edge that loads the response, so a
//   new request is taken only after the previous response has been loaded.
// Reset:
//   arst_n empties the table at once (valid bits cleared); no sweep.
// Stall:
//   rsp holds while not ready; a finished result waits at the chain tail
//   until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_max_table import kmt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEFAULT
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	kmt_chan_if.sink   req,
	kmt_chan_if.source rsp
);

	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_MATCH = 2'd1;
	localparam logic [1:0] S_WAVE  = 2'd2;
	localparam logic [1:0] S_WAIT  = 2'd3;

	logic [1:0]       state_q;
	cmd_t             cmd_q;
	logic             launch_q;
	logic [ENTRIES-1:0] match_vec;
	carry_t           carry [ENTRIES+1];
	logic [CNT_W-1:0] count [ENTRIES+1];
	logic             out_free;
	logic             load;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	req_t             req_data;
	logic [CNT_W+COUNT_W-1:0] count_ext;

	assign req_data  = req.payload;
	assign req.ready = (state_q == S_IDLE);

	assign out_free = !rsp_valid_q || rsp.ready;
	assign load     = (state_q == S_WAIT) && out_free;

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			launch_q <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					launch_q <= 1'b1;
					state_q  <= S_WAVE;
				end
				S_WAVE: begin
					if (carry[ENTRIES].strobe) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command register, broadcast to all cells for the whole wave
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q.cmd    <= req_data.cmd;
			cmd_q.key    <= req_data.key;
			cmd_q.amount <= req_data.amount;
		end
		if (state_q == S_MATCH) begin
			cmd_q.hit <= |match_vec;
		end
	end

	// head of the chain: empty record, strobe starts the wave
	assign carry[0] = '{strobe: launch_q, any: 1'b0, best: '0, claimed: 1'b0};
	assign count[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kmt_cell #(
			.CNT_W(CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd_bus  (cmd_q),
			.match    (match_vec[i]),
			.up_carry (carry[i]),
			.up_count (count[i]),
			.dn_carry (carry[i+1]),
			.dn_count (count[i+1])
		);
	end

	assign count_ext = {{COUNT_W{1'b0}}, count[ENTRIES]};

	// output register; tail record holds until it is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.max_value   <= carry[ENTRIES].any ? carry[ENTRIES].best : '0;
			rsp_q.entry_count <= count_ext[COUNT_W-1:0];
			rsp_q.dropped     <= (cmd_q.cmd == OP_SET) && !carry[ENTRIES].claimed;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule

`default_nettype wire

// ----- hw/rtl/kmt_cell.sv -----
// ----------------------------------------------------------------------------
// kmt_cell - one slot of the keyed max table
// Holds key, amount and valid. When the wave reaches it, applies the
// command to its slot and folds its entry into the running max and count.
// ----------------------------------------------------------------------------
`default_nettype none

module kmt_cell import kmt_pkg::*; #(
	parameter int CNT_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd_bus,
	output logic                  match,
	input  wire carry_t           up_carry,
	input  wire logic [CNT_W-1:0] up_count,
	output carry_t                dn_carry,
	output logic [CNT_W-1:0]      dn_count
);

	logic                     valid_q;
	logic signed [DATA_W-1:0] key_q;
	logic signed [DATA_W-1:0] amount_q;
	logic                     set_here;
	logic                     rem_here;
	logic                     new_valid;
	logic signed [DATA_W-1:0] new_amount;
	logic                     take;
	logic                     strobe_q;
	logic                     any_q;
	logic signed [DATA_W-1:0] best_q;
	logic                     claimed_q;
	logic [CNT_W-1:0]         count_q;

	assign match = valid_q && (key_q == cmd_bus.key);

	// a new key goes to the first free slot the wave meets
	assign set_here = (cmd_bus.cmd == OP_SET) &&
		(match || (!cmd_bus.hit && !valid_q && !up_carry.claimed));
	assign rem_here = (cmd_bus.cmd == OP_REMOVE) && match;

	assign new_valid  = set_here ? 1'b1 : (rem_here ? 1'b0 : valid_q);
	assign new_amount = set_here ? cmd_bus.amount : amount_q;
	assign take       = new_valid && (!up_carry.any || (new_amount > up_carry.best));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_carry.strobe) begin
			valid_q <= new_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_carry.strobe && set_here) begin
			key_q    <= cmd_bus.key;
			amount_q <= cmd_bus.amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= up_carry.strobe;
		end
	end

	// payload of the record only moves with the wave
	always_ff @(posedge clk) begin
		if (up_carry.strobe) begin
			any_q     <= up_carry.any | take;
			best_q    <= take ? new_amount : up_carry.best;
			claimed_q <= up_carry.claimed | set_here;
			count_q   <= up_count + CNT_W'(new_valid);
		end
	end

	assign dn_carry = '{strobe: strobe_q, any: any_q, best: best_q, claimed: claimed_q};
	assign dn_count = count_q;

endmodule

`default_nettype wire

// ----- hw/rtl/kmt_checker.sv -----
// ----------------------------------------------------------------------------
// kmt_checker - port-level checks of the keyed max table
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kmt_checker import kmt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp_data
);

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(ENTRIES);
	localparam logic               SMALL      = (ENTRIES < (1 << COUNT_W));

	// response held while stalled
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	// one request in flight: no accept right after an accept
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another in flight");

	// a refused key means the table is full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.dropped |-> rsp_data.entry_count == FULL_COUNT)
		else $error("dropped with free slots");

	// count bound and empty-table maximum
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && SMALL |-> rsp_data.entry_count <= FULL_COUNT)
		else $error("entry count above table size");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && SMALL && (rsp_data.entry_count == '0) |-> rsp_data.max_value == '0)
		else $error("empty table reports nonzero max");

endmodule

bind keyed_max_table kmt_checker #(
	.ENTRIES(ENTRIES)
) u_kmt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.payload)
);

`default_nettype wire

// ----- dv/kmt_table_checker.sv -----
// ----------------------------------------------------------------------------
// kmt_table_checker - response predictor and scoreboard for keyed_max_table
// Mirrors the key/amount table on every accepted request and compares each
// accepted response, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module kmt_table_checker import kmt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req_payload,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp_payload,
	output int   fail_count,
	output int   pending
);

	// mirror of the table; key/amount are only read where the slot is in use
	logic [DATA_W-1:0]        slot_keys    [ENTRIES];
	logic signed [DATA_W-1:0] slot_amounts [ENTRIES];
	bit                       slot_used    [ENTRIES];

	rsp_t expected_rsps[$];

	// applies one command to the mirror and returns the response it must give
	function automatic rsp_t apply_command(input req_t r);
		int                       hit;
		int                       free_slot;
		int                       held;
		bit                       any;
		logic signed [DATA_W-1:0] peak;
		rsp_t                     res;
		hit       = -1;
		free_slot = -1;
		held      = 0;
		any       = 1'b0;
		peak      = '0;
		res       = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_used[i] && slot_keys[i] == r.key && hit < 0)
				hit = i;
			if (!slot_used[i] && free_slot < 0)
				free_slot = i;
		end
		if (r.cmd == OP_SET) begin
			if (hit < 0)
				hit = free_slot;
			if (hit < 0) begin
				res.dropped = 1'b1;
			end else begin
				slot_keys[hit]    = r.key;
				slot_amounts[hit] = r.amount;
				slot_used[hit]    = 1'b1;
			end
		end else if (hit >= 0) begin
			slot_used[hit] = 1'b0;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_used[i]) begin
				held++;
				if (!any || slot_amounts[i] > peak)
					peak = slot_amounts[i];
				any = 1'b1;
			end
		end
		res.max_value   = peak;
		res.entry_count = held[COUNT_W-1:0];
		return res;
	endfunction

	task automatic note_mismatch(input string field, input string want, input string got);
		fail_count++;
		$error("%s mismatch: expected %s, got %s", field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			foreach (slot_used[i])
				slot_used[i] = 1'b0;
			expected_rsps.delete();
			pending = 0;
		end else begin
			// check the response first; a new request is always younger
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					fail_count++;
					$error("response with no request outstanding: max_value %0d count %0d",
						rsp_payload.max_value, rsp_payload.entry_count);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_payload.max_value !== want.max_value)
						note_mismatch("max_value", $sformatf("%0d", want.max_value),
							$sformatf("%0d", rsp_payload.max_value));
					if (rsp_payload.entry_count !== want.entry_count)
						note_mismatch("entry_count", $sformatf("%0d", want.entry_count),
							$sformatf("%0d", rsp_payload.entry_count));
					if (rsp_payload.dropped !== want.dropped)
						note_mismatch("dropped", $sformatf("%0b", want.dropped),
							$sformatf("%0b", rsp_payload.dropped));
				end
			end
			if (req_valid && req_ready)
				expected_rsps.insert(expected_rsps.size(), apply_command(req_payload));
			pending = expected_rsps.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - top level for keyed_max_table
// Drives set/remove requests with random gaps, stalls the response side at
// random and lets kmt_table_checker predict and compare every response.
// ----------------------------------------------------------------------------
module testbench;
	import kmt_pkg::*;

	localparam int TABLE_DEPTH  = ENTRIES_DEFAULT;
	localparam int RANDOM_ITEMS = 1426;
	localparam int KEY_POOL     = 24;           // more keys than slots: forces full-table drops
	localparam int CYCLE_LIMIT  = 600000;
	localparam int MAX_WAIT     = 18;
	localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;

	logic        clk;
	logic        arst_n;
	int          fail_count;
	int          pending;
	int unsigned cycle_count;
	int          sent;
	int          taken;

	kmt_chan_if #(.payload_t(req_t)) req_ch ();
	kmt_chan_if #(.payload_t(rsp_t)) rsp_ch ();

	keyed_max_table #(.ENTRIES(TABLE_DEPTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	kmt_table_checker #(.ENTRIES(TABLE_DEPTH)) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_ch.valid),
		.req_ready   (req_ch.ready),
		.req_payload (req_ch.payload),
		.rsp_valid   (rsp_ch.valid),
		.rsp_ready   (rsp_ch.ready),
		.rsp_payload (rsp_ch.payload),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle draw shared by both sides. Every fifth stretch of 48 transfers runs
	// with no idling at all so back-to-back traffic is covered too; otherwise a
	// random idle of up to MAX_WAIT, which lands gaps throughout the chain walk.
	function automatic int pick_wait(input int n);
		if ((n / 48) % 5 == 4)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// One request: optional gap, then hold valid until accepted. valid is only
	// lowered when a gap follows, so it never sees two NBAs in one step.
	task automatic issue(input logic cmd, input logic signed [DATA_W-1:0] key,
		input logic signed [DATA_W-1:0] amount);
		int   gap;
		req_t r;
		gap      = pick_wait(sent);
		r.cmd    = cmd;
		r.key    = key;
		r.amount = amount;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (!req_ch.ready);
		sent++;
	endtask

	// Watchdog: a lost response or a hung handshake ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Response side: random stall per response, ready held while waiting.
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		taken        = 0;
		@(posedge arst_n);
		forever begin
			stall = pick_wait(taken);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			taken++;
		end
	end

	initial begin
		logic signed [DATA_W-1:0] key_pool [KEY_POOL];
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] amount;
		int                       set_pct;
		logic                     cmd;

		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		arst_n         = 1'b0;
		cycle_count    = 0;
		sent           = 0;
		set_pct        = 85;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// --- directed: corner amounts and keys, fill to full, the special cases
		issue(OP_REMOVE, 32'sd5, 32'sd123);        // remove on an empty table
		issue(OP_SET, S_MIN, S_MIN);               // single entry, most negative max
		issue(OP_SET, S_MAX, S_MAX);
		issue(OP_SET, S_MIN, 32'sd0);              // update in place, count unchanged
		issue(OP_SET, 32'sd0, -32'sd1);
		issue(OP_SET, -32'sd1, 32'sd7);
		for (int k = 1; k <= TABLE_DEPTH - 4; k++)
			issue(OP_SET, k, -k * 1000);           // table now full (count 16)
		issue(OP_SET, 32'sd99, S_MAX);             // new key into a full table: dropped
		issue(OP_SET, 32'sd3, S_MAX);              // existing key while full: updated
		issue(OP_REMOVE, S_MAX, 32'sd0);           // max survives through key 3
		issue(OP_REMOVE, 32'sd1234, S_MIN);        // absent key on a busy table
		issue(OP_SET, 32'sd99, 32'sd5);            // new key reuses the freed slot
		issue(OP_REMOVE, 32'sd3, S_MIN);           // max falls back to a lower amount

		// --- random: small key pool keeps hits, fills and drains frequent
		key_pool[0] = S_MIN;
		key_pool[1] = S_MAX;
		key_pool[2] = 32'sd0;
		key_pool[3] = -32'sd1;
		for (int p = 4; p < KEY_POOL; p++)
			key_pool[p] = $urandom;

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// phases of fill-heavy, balanced and drain-heavy traffic
			if (i % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						set_pct = 85;
					end
					1: begin
						set_pct = 50;
					end
					default: begin
						set_pct = 25;
					end
				endcase
			end
			cmd = ($urandom_range(0, 99) < set_pct) ? OP_SET : OP_REMOVE;
			if ($urandom_range(0, 9) == 0)
				key = $urandom;                    // almost surely a new key
			else
				key = key_pool[$urandom_range(0, KEY_POOL - 1)];
			case ($urandom_range(0, 15))
				0: amount = S_MIN;
				1: amount = S_MAX;
				2: amount = 32'sd0;
				3: amount = -32'sd1;
				4: amount = $urandom_range(0, 7);  // narrow range for ties
				default: amount = $urandom;
			endcase
			issue(cmd, key, amount);
		end
		req_ch.valid <= 1'b0;

		// one edge so the last prediction is queued, then drain and settle
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
